// ===== rtl/srps_pkg.sv =====
`default_nettype none
package srps_pkg;

	// Width of the stack pointer and merge counts; covers a stack of up to 64 entries.
	localparam int TOP_W = 7;

	// One classified item as it travels from the front part to the back part.
	typedef struct packed {
		logic [63:0]      value;
		logic             last;
		logic [TOP_W-1:0] merges;
		logic             full;
	} cmd_t;

	// Quiet NaN produced for an invalid operation such as +inf plus -inf.
	localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

endpackage
`default_nettype wire

// ===== rtl/srps_ram.sv =====
`default_nettype none
module srps_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/srps_fadd.sv =====
`default_nettype none
module srps_fadd (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic      [63:0] res
);
	import srps_pkg::*;

	typedef enum logic [4:0] {
		FA_IDLE = 5'b00001,
		FA_ALN  = 5'b00010,
		FA_ADD  = 5'b00100,
		FA_NRM  = 5'b01000,
		FA_RND  = 5'b10000
	} fa_st_t;

	fa_st_t      st_q;
	logic        sgn_q, sub_q, spec_q;
	logic [63:0] spec_val_q;
	logic [11:0] exp_q;
	logic [10:0] d_q;
	logic [55:0] mx_q, my_q;
	logic [56:0] sum_q;

	logic        a_big, a_nan, b_nan, a_inf, b_inf;
	logic [63:0] big, sml;
	logic [10:0] e_big, e_sml;
	logic [52:0] m_big, m_sml;
	logic [55:0] sh_val, lost_mask;
	logic [53:0] rnd_m;
	logic [11:0] rnd_e;
	logic        inc, res_sgn;
	logic [63:0] rnd_res;

	always_comb begin
		a_big = a[62:0] >= b[62:0];
		big   = a_big ? a : b;
		sml   = a_big ? b : a;
		e_big = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
		e_sml = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
		m_big = {big[62:52] != 11'd0, big[51:0]};
		m_sml = {sml[62:52] != 11'd0, sml[51:0]};
		a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
		b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
		a_inf = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
		b_inf = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
	end

	always_comb begin
		sh_val    = my_q >> d_q[5:0];
		lost_mask = (56'd1 << d_q[5:0]) - 56'd1;
	end

	always_comb begin
		inc   = sum_q[2] & (sum_q[1] | sum_q[0] | sum_q[3]);
		rnd_m = {1'b0, sum_q[55:3]} + {53'd0, inc};
		rnd_e = exp_q;
		if (rnd_m[53]) begin
			rnd_m = rnd_m >> 1;
			rnd_e = exp_q + 12'd1;
		end
		res_sgn = (sum_q == 57'd0) ? (sgn_q & ~sub_q) : sgn_q;
		if (rnd_e >= 12'd2047) begin
			rnd_res = {res_sgn, 11'h7FF, 52'd0};
		end else begin
			rnd_res = {res_sgn, rnd_m[52] ? rnd_e[10:0] : 11'd0, rnd_m[51:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= FA_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				FA_IDLE: begin
					if (start) begin
						st_q <= FA_ALN;
					end
				end
				FA_ALN: begin
					st_q <= FA_ADD;
				end
				FA_ADD: begin
					st_q <= spec_q ? FA_RND : FA_NRM;
				end
				FA_NRM: begin
					// An exact zero needs no normalizing and rounds straight away.
					if (sum_q[56] || sum_q == 57'd0) begin
						st_q <= FA_RND;
					end else if (!(sum_q[55:48] == 8'd0 && exp_q > 12'd8)
						&& !(!sum_q[55] && exp_q > 12'd1)) begin
						st_q <= FA_RND;
					end
				end
				FA_RND: begin
					st_q <= FA_IDLE;
					done <= 1'b1;
				end
				default: st_q <= FA_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			FA_IDLE: begin
				if (start) begin
					sgn_q  <= big[63];
					sub_q  <= a[63] ^ b[63];
					exp_q  <= {1'b0, e_big};
					d_q    <= e_big - e_sml;
					mx_q   <= {m_big, 3'b000};
					my_q   <= {m_sml, 3'b000};
					spec_q <= a_nan | b_nan | a_inf | b_inf;
					if (a_nan) begin
						spec_val_q <= a | 64'h0008_0000_0000_0000;
					end else if (b_nan) begin
						spec_val_q <= b | 64'h0008_0000_0000_0000;
					end else if (a_inf && b_inf && (a[63] != b[63])) begin
						spec_val_q <= DEFAULT_NAN;
					end else if (a_inf) begin
						spec_val_q <= a;
					end else begin
						spec_val_q <= b;
					end
				end
			end
			FA_ALN: begin
				if (d_q >= 11'd56) begin
					my_q <= {55'd0, |my_q};
				end else begin
					my_q <= {sh_val[55:1], sh_val[0] | (|(my_q & lost_mask))};
				end
			end
			FA_ADD: begin
				sum_q <= sub_q ? ({1'b0, mx_q} - {1'b0, my_q}) : ({1'b0, mx_q} + {1'b0, my_q});
			end
			FA_NRM: begin
				if (sum_q[56]) begin
					sum_q <= {1'b0, sum_q[56:2], sum_q[1] | sum_q[0]};
					exp_q <= exp_q + 12'd1;
				end else if (sum_q[55:48] == 8'd0 && exp_q > 12'd8) begin
					sum_q <= sum_q << 8;
					exp_q <= exp_q - 12'd8;
				end else if (!sum_q[55] && exp_q > 12'd1) begin
					sum_q <= sum_q << 1;
					exp_q <= exp_q - 12'd1;
				end
			end
			FA_RND: begin
				res <= spec_q ? spec_val_q : rnd_res;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/srps_front.sv =====
`default_nettype none
module srps_front #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic [63:0]    value,
	input  wire logic           last,
	output logic                cmd_valid,
	output srps_pkg::cmd_t      cmd,
	input  wire logic           cmd_pop
);
	import srps_pkg::*;

	logic [63:0]      count_q;
	logic [TOP_W-1:0] top_q;
	cmd_t             queue_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       fill_q;

	logic [64:0]      inc65, lowest_zero;
	logic [TOP_W-1:0] tz, merges, after;
	logic             push, full;
	cmd_t             new_cmd;

	// The number of merges is the count of trailing one bits, capped by the stack height.
	always_comb begin
		inc65       = {1'b0, count_q} + 65'd1;
		lowest_zero = ~{1'b0, count_q} & inc65;
		tz          = '0;
		for (int i = 0; i < 65; i++) begin
			if (lowest_zero[i]) begin
				tz = tz | TOP_W'(i);
			end
		end
		merges = (tz < top_q) ? tz : top_q;
		after  = top_q - merges;
		full   = after == TOP_W'(STACK_DEPTH);
		new_cmd = '{value: value, last: last, merges: merges, full: full};
	end

	assign in_stall  = fill_q == 2'd2;
	assign push      = in_valid && !in_stall;
	assign cmd_valid = fill_q != 2'd0;
	assign cmd       = queue_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			top_q   <= '0;
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			fill_q  <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
				if (last) begin
					count_q <= '0;
					top_q   <= '0;
				end else begin
					count_q <= inc65[63:0];
					top_q   <= full ? after : after + TOP_W'(1);
				end
			end
			if (cmd_pop && cmd_valid) begin
				rp_q <= ~rp_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, cmd_pop && cmd_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wp_q] <= new_cmd;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/srps_back.sv =====
`default_nettype none
module srps_back #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	input  wire srps_pkg::cmd_t cmd,
	output logic                cmd_pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [63:0]         total
);
	import srps_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_MRG  = 6'b000010,
		B_WT   = 6'b000100,
		B_ADD  = 6'b001000,
		B_DRN  = 6'b010000,
		B_OUT  = 6'b100000
	} b_st_t;

	typedef enum logic [2:0] {
		PH_MERGE = 3'b001,
		PH_FULL  = 3'b010,
		PH_DRAIN = 3'b100
	} ph_t;

	b_st_t            st_q;
	ph_t              ph_q;
	logic [TOP_W-1:0] top_q, merges_q;
	logic             full_q, last_q;
	logic [63:0]      acc_q;

	logic             we, fa_start, fa_done;
	logic [AW-1:0]    waddr, raddr;
	logic [63:0]      wdata, rdata, fa_res;
	logic [TOP_W-1:0] top_m1;

	assign top_m1   = top_q - TOP_W'(1);
	assign cmd_pop  = (st_q == B_IDLE) && cmd_valid;
	assign fa_start = st_q == B_WT;

	always_comb begin
		we    = 1'b0;
		waddr = top_q[AW-1:0];
		wdata = acc_q;
		raddr = top_m1[AW-1:0];
		if (st_q == B_MRG && merges_q == '0 && full_q) begin
			raddr = AW'(STACK_DEPTH - 1);
		end
		if (st_q == B_MRG && merges_q == '0 && !full_q) begin
			we = 1'b1;
		end
		if (st_q == B_ADD && fa_done && ph_q == PH_FULL) begin
			we    = 1'b1;
			waddr = AW'(STACK_DEPTH - 1);
			wdata = fa_res;
		end
	end

	srps_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	srps_fadd u_fadd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fa_start),
		.a      (acc_q),
		.b      (rdata),
		.done   (fa_done),
		.res    (fa_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_IDLE;
			ph_q      <= PH_MERGE;
			top_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (st_q == B_OUT && (!out_valid || !out_stall)) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (st_q)
				B_IDLE: begin
					if (cmd_valid) begin
						st_q <= B_MRG;
					end
				end
				B_MRG: begin
					if (merges_q != '0) begin
						ph_q <= PH_MERGE;
						st_q <= B_WT;
					end else if (full_q) begin
						ph_q <= PH_FULL;
						st_q <= B_WT;
					end else begin
						top_q <= top_q + TOP_W'(1);
						st_q  <= last_q ? B_DRN : B_IDLE;
					end
				end
				B_WT: begin
					st_q <= B_ADD;
				end
				B_ADD: begin
					if (fa_done) begin
						case (ph_q)
							PH_MERGE: begin
								top_q <= top_m1;
								st_q  <= B_MRG;
							end
							PH_FULL: begin
								st_q <= last_q ? B_DRN : B_IDLE;
							end
							PH_DRAIN: begin
								top_q <= top_m1;
								st_q  <= B_DRN;
							end
							default: st_q <= B_IDLE;
						endcase
					end
				end
				B_DRN: begin
					if (top_q == '0) begin
						st_q <= B_OUT;
					end else begin
						ph_q <= PH_DRAIN;
						st_q <= B_WT;
					end
				end
				B_OUT: begin
					if (!out_valid || !out_stall) begin
						st_q <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			acc_q    <= cmd.value;
			merges_q <= cmd.merges;
			full_q   <= cmd.full;
			last_q   <= cmd.last;
		end
		if (st_q == B_MRG && merges_q == '0 && !full_q) begin
			acc_q <= 64'd0;
		end
		if (st_q == B_ADD && fa_done) begin
			acc_q <= (ph_q == PH_FULL) ? 64'd0 : fa_res;
			if (ph_q == PH_MERGE) begin
				merges_q <= merges_q - TOP_W'(1);
			end
		end
		if (st_q == B_OUT && (!out_valid || !out_stall)) begin
			total <= acc_q;
		end
	end

	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= TOP_W'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_out_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q == B_OUT))
		else $error("result raised outside the output step");

	a_done_in_add: assert property (@(posedge clk) disable iff (!arst_n)
		fa_done |-> st_q == B_ADD)
		else $error("adder finished while the sequencer was not waiting");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> st_q == B_MRG)
		else $error("item taken from the queue without being started");
endmodule
`default_nettype wire

// ===== rtl/shift_reduce_pairwise_sum_unit.sv =====
// Each item takes its steps in the back part plus one adder pass per merge; an infinite or
// NaN operand skips the normalize shifts. A push onto a full stack adds a pass.
// A last item adds one pass per remaining stack entry, then the total is presented.
// The back part takes a new item only when done with the previous one and its merges, as all
// passes share the single binary64 adder; a two-item queue decouples input from the back part.
// Reset (arst_n low, asynchronous): counts, stack pointers, queue and result valid clear.
`default_nettype none
module shift_reduce_pairwise_sum_unit #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] value,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [63:0] total
);
	import srps_pkg::*;

	// The front part counts items and tracks the stack height, so it can tell the back part
	// how many merges each item needs and whether the stack is full at its push.
	cmd_t cmd;
	logic cmd_valid, cmd_pop;

	srps_front #(.STACK_DEPTH(STACK_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.last      (last),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// The back part runs the merges, the push and the final drain through one adder and
	// the stack memory, and holds the total in an output register until it is taken.
	srps_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.total     (total)
	);
endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
module tb;
	import srps_pkg::*;

	// One item as the sender presents it: an addend and the end-of-sequence mark.
	typedef struct {
		logic [63:0] value;
		logic        last;
	} addend_t;

	localparam int STACK_DEPTH = 64;
	localparam int HALF_PERIOD = 6;
	localparam int PHASE_ITEMS = 220;
	localparam int DRAIN_CYCLES = 400;
	localparam longint LIMIT_CYCLES = 1000000;

	localparam logic [63:0] POS_ZERO = 64'h0000_0000_0000_0000;
	localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
	localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] NEG_INF = 64'hFFF0_0000_0000_0000;
	localparam logic [63:0] MAX_NORMAL = 64'h7FEF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MIN_SUBNORMAL = 64'h0000_0000_0000_0001;
	localparam logic [63:0] MAX_SUBNORMAL = 64'h000F_FFFF_FFFF_FFFF;
	localparam logic [63:0] SIGNAL_NAN = 64'h7FF0_0000_0000_0001;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] value;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] total;

	shift_reduce_pairwise_sum_unit #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.total(total)
	);

	// Items waiting for the driver, and sequence totals waiting for the monitor.
	addend_t     pending_items[$];
	logic [63:0] expected_totals[$];
	int          mismatches;

	// Percentages of idle cycles on each side, changed between phases.
	int send_idle_pct;
	int recv_stall_pct;

	// The predictor's own copy of the block's state.
	logic [63:0] sum_stack[STACK_DEPTH];
	int          sum_depth;
	logic [63:0] seq_count;

	always #HALF_PERIOD clk = ~clk;

	function automatic logic is_nan(input logic [63:0] x);
		return x[62:52] == 11'h7FF && x[51:0] != 52'd0;
	endfunction

	// Binary64 addition a + b. Ordinary operands go through the simulator's real
	// type, which is binary64 with round-to-nearest-even. NaN operands are handled
	// here so that the propagated payload is defined: the first NaN operand wins
	// and is made quiet, and an infinity minus itself gives the default NaN.
	function automatic logic [63:0] fp_add(input logic [63:0] a, input logic [63:0] b);
		if (is_nan(a))
			return a | 64'h0008_0000_0000_0000;
		if (is_nan(b))
			return b | 64'h0008_0000_0000_0000;
		if (a[62:0] == POS_INF[62:0] && b[62:0] == POS_INF[62:0] && a[63] != b[63])
			return DEFAULT_NAN;
		return $realtobits($bitstoreal(a) + $bitstoreal(b));
	endfunction

	// Folds one accepted item into the predicted stack. Each trailing one bit of
	// the item count pops the top entry into the incoming value. A sequence's
	// last item drains the stack from the top into a sum that starts at +0.0.
	task automatic absorb_addend(input logic [63:0] x, input logic is_last);
		logic [63:0] acc;
		logic [63:0] sum;
		int          b;
		acc = x;
		for (b = 0; b < 64; b++) begin
			if (!seq_count[b] || sum_depth == 0)
				break;
			acc = fp_add(acc, sum_stack[sum_depth-1]);
			sum_depth--;
		end
		// A full stack does not grow: the value is folded into its top entry.
		if (sum_depth >= STACK_DEPTH) begin
			sum_stack[STACK_DEPTH-1] = fp_add(acc, sum_stack[STACK_DEPTH-1]);
		end else begin
			sum_stack[sum_depth] = acc;
			sum_depth++;
		end
		seq_count++;
		if (is_last) begin
			sum = POS_ZERO;
			while (sum_depth > 0) begin
				sum_depth--;
				sum = fp_add(sum, sum_stack[sum_depth]);
			end
			expected_totals.push_back(sum);
			seq_count = '0;
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// Draws one addend. Most draws are random bit patterns or values of moderate
	// size, so that sums round and cancel; the rest are zeros, infinities, NaNs,
	// subnormals and values near overflow.
	function automatic logic [63:0] draw_addend();
		logic [63:0] x;
		x = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2: ;
			3: begin
				case ($urandom_range(0, 8))
					0: x = POS_ZERO;
					1: x = NEG_ZERO;
					2: x = POS_INF;
					3: x = NEG_INF;
					4: x = DEFAULT_NAN;
					5: x = SIGNAL_NAN;
					6: x = MAX_NORMAL | {1'($urandom_range(0, 1)), 63'd0};
					7: x = MIN_SUBNORMAL | {1'($urandom_range(0, 1)), 63'd0};
					default: x = MAX_SUBNORMAL;
				endcase
			end
			4: x = $realtobits(real'($urandom_range(0, 2000)) - 1000.0);
			5, 6, 7: x[62:52] = 11'd1023 + 11'($urandom_range(0, 20)) - 11'd10;
			8: x[62:52] = 11'd0;
			default: x[62:52] = 11'h7FE - 11'($urandom_range(0, 3));
		endcase
		return x;
	endfunction

	task automatic queue_sequence(input int len);
		addend_t it;
		int      i;
		for (i = 0; i < len; i++) begin
			it.value = draw_addend();
			it.last = (i == len - 1);
			pending_items.push_back(it);
		end
	endtask

	task automatic queue_fixed(input logic [63:0] x, input logic is_last);
		addend_t it;
		it.value = x;
		it.last = is_last;
		pending_items.push_back(it);
	endtask

	// Whole sequences until the phase holds enough items. Most sequences are
	// short, a few long ones push the stack several levels deep.
	task automatic queue_random_phase();
		int n;
		int len;
		n = 0;
		while (n < PHASE_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(60, 300);
			else
				len = $urandom_range(1, 24);
			queue_sequence(len);
			n += len;
		end
	endtask

	// Waits until every item is accepted and every total is checked, then lets the
	// block settle before the idle pattern changes.
	task automatic drain_phase();
		while (pending_items.size() != 0 || in_valid || expected_totals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Driver. The item on the port is folded into the predictor at the edge that
	// accepts it. A new item, or a gap, is chosen only when the port is free, so a
	// stalled item never changes.
	always @(posedge clk or negedge arst_n) begin
		addend_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
			last <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				absorb_addend(value, last);
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					it = pending_items.pop_front();
					in_valid <= 1'b1;
					value <= it.value;
					last <= it.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Each accepted total is checked against the oldest predicted one,
	// and the stall is redrawn every cycle.
	always @(posedge clk or negedge arst_n) begin
		logic [63:0] want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_totals.size() == 0) begin
					report_mismatch($sformatf("total %h with no sequence ended", total));
				end else begin
					want = expected_totals.pop_front();
					if (total !== want)
						report_mismatch($sformatf("total %h, predicted %h", total, want));
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		sum_depth = 0;
		seq_count = '0;
		in_valid = 1'b0;
		value = '0;
		last = 1'b0;
		out_stall = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: single-item sequences at the extremes of the value field,
		// including both zeros, NaNs and a subnormal; an infinity minus itself;
		// overflow to infinity; and sequences whose lengths cross powers of two so
		// that merges of one, two and three levels happen before the drain.
		queue_fixed(POS_ZERO, 1'b1);
		queue_fixed(NEG_ZERO, 1'b1);
		queue_fixed(ALL_ONES, 1'b1);
		queue_fixed(MIN_SUBNORMAL, 1'b1);
		queue_fixed(SIGNAL_NAN, 1'b1);
		queue_fixed(POS_INF, 1'b0);
		queue_fixed(NEG_INF, 1'b1);
		queue_fixed(MAX_NORMAL, 1'b0);
		queue_fixed(MAX_NORMAL, 1'b1);
		queue_fixed(NEG_ZERO, 1'b0);
		queue_fixed(NEG_ZERO, 1'b1);
		queue_sequence(3);
		queue_sequence(4);
		queue_sequence(8);
		drain_phase();

		// Random part in four idle patterns: none, a slow sender, a slow receiver,
		// and both sides idling now and then.
		queue_random_phase();
		drain_phase();
		send_idle_pct = 85;
		queue_random_phase();
		drain_phase();
		send_idle_pct = 0;
		recv_stall_pct = 85;
		queue_random_phase();
		drain_phase();
		send_idle_pct = 17;
		recv_stall_pct = 17;
		queue_random_phase();
		drain_phase();

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#(LIMIT_CYCLES * 2 * HALF_PERIOD);
		$display("FAIL");
		$finish;
	end

endmodule
